// ===== src/abds_pkg.sv =====
// Package with the beat types, register indexes and fixed-point constants of the anchor decoder.
package abds_pkg;

    typedef struct packed {
        logic [15:0]        face_score;
        logic signed [15:0] offset_cx;
        logic signed [15:0] offset_cy;
        logic signed [15:0] offset_w;
        logic signed [15:0] offset_h;
        logic [15:0]        anchor_cx;
        logic [15:0]        anchor_cy;
        logic [15:0]        anchor_w;
        logic [15:0]        anchor_h;
    } abds_in_t;

    typedef struct packed {
        logic [12:0] box_x;
        logic [12:0] box_y;
        logic [12:0] box_width;
        logic [12:0] box_height;
        logic [15:0] kept_score;
    } abds_out_t;

    typedef enum logic [2:0] {
        REG_SCORE_THRESHOLD = 3'd0,
        REG_CENTER_VARIANCE = 3'd1,
        REG_SIZE_VARIANCE   = 3'd2,
        REG_IMAGE_WIDTH     = 3'd3,
        REG_IMAGE_HEIGHT    = 3'd4
    } abds_reg_t;

    localparam int unsigned AXIS_STAGES = 6;

    localparam int unsigned MAX_IMAGE_SIDE = 4096;

    localparam logic [15:0] RST_SCORE_THRESHOLD = 16'd45875;
    localparam logic [15:0] RST_CENTER_VARIANCE = 16'd6554;
    localparam logic [15:0] RST_SIZE_VARIANCE   = 16'd13107;
    localparam logic [12:0] RST_IMAGE_WIDTH     = 13'd640;
    localparam logic [12:0] RST_IMAGE_HEIGHT    = 13'd480;

    localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
    localparam longint unsigned LN2_Q30 = 64'd744261118;

endpackage

// ===== src/abds_axis.sv =====
// One axis of the anchor decoder: centre and size decode, clipping and scaling to pixels.
module abds_axis #(
    parameter int unsigned EXP_TABLE_DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic [abds_pkg::AXIS_STAGES-1:0]     en,
    input  logic signed [15:0]                   off_c,
    input  logic signed [15:0]                   off_s,
    input  logic [15:0]                          anchor_c,
    input  logic [15:0]                          anchor_s,
    input  logic [15:0]                          center_variance,
    input  logic [15:0]                          size_variance,
    input  logic [12:0]                          side,
    output logic [12:0]                          pos,
    output logic [12:0]                          len
);
    import abds_pkg::*;

    localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH);

    // Shift and subtract quotient, used only while the table is built.
    function automatic longint unsigned div_u64(input longint unsigned a,
                                                input longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], a[i]};
            if (r >= b)
            begin
                r = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [31:0] pow2_entry(input int unsigned k);
        longint unsigned x;
        longint unsigned sum;
        longint unsigned term;
        x = div_u64(longint'(k) * LN2_Q30, EXP_TABLE_DEPTH);
        sum = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int unsigned j = 1; j <= 24; j++)
        begin
            term = div_u64((term * x) >> 30, j);
            sum = sum + term;
        end
        return sum[31:0];
    endfunction

    logic [31:0] pow2_rom [EXP_TABLE_DEPTH];

    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++)
    begin : g_rom
        localparam logic [31:0] ENTRY = pow2_entry(g);
        assign pow2_rom[g] = ENTRY;
    end

    // Stage 1
    logic signed [32:0] pc_reg;
    logic signed [32:0] t_reg;
    logic [15:0]        ac1_reg;
    logic [15:0]        as1_reg;
    // Stage 2
    logic signed [49:0] cm_reg;
    logic signed [64:0] yl_reg;
    logic [15:0]        ac2_reg;
    logic [15:0]        as2_reg;
    // Stage 3
    logic [31:0]        exp_reg;
    logic signed [6:0]  n3_reg;
    logic signed [22:0] c3_reg;
    logic [15:0]        as3_reg;
    // Stage 4
    logic [47:0]        m_reg;
    logic signed [6:0]  n4_reg;
    logic signed [22:0] c4_reg;
    // Stage 5
    logic [17:0]        lo_reg;
    logic [16:0]        sz_reg;
    // Stage 6
    logic [12:0]        pos_reg;
    logic [12:0]        len_reg;

    logic [27:0]            frac;
    logic [43:0]            idx_prod;
    logic [15:0]            idx_full;
    logic [IDX_W-1:0]       idx;
    logic signed [22:0]     c_next;
    logic [6:0]             shamt;
    logic [47:0]            m_shift;
    logic [28:0]            sz_full;
    logic signed [31:0]     lo_full;
    logic [17:0]            lo_next;
    logic [16:0]            sz_next;
    logic [30:0]            pos_prod;
    logic [29:0]            len_prod;

    always_comb
    begin
        frac = yl_reg[57:30];
        idx_prod = 44'(frac) * 44'(EXP_TABLE_DEPTH);
        idx_full = idx_prod[43:28];
        if (32'(idx_full) >= EXP_TABLE_DEPTH)
        begin
            idx = IDX_W'(EXP_TABLE_DEPTH - 1);
        end
        else
        begin
            idx = idx_full[IDX_W-1:0];
        end
        c_next = 23'($signed(cm_reg[49:28])) + $signed({7'd0, ac2_reg});

        shamt = 7'd30 - n4_reg;
        m_shift = m_reg >> shamt;
        sz_full = m_shift[28:0];
        lo_full = ($signed(32'(c4_reg)) <<< 1) - $signed({3'd0, sz_full});
        if (lo_full < 0)
        begin
            lo_next = 18'd0;
        end
        else if (lo_full > 32'sd131072)
        begin
            lo_next = 18'd131072;
        end
        else
        begin
            lo_next = lo_full[17:0];
        end
        if (sz_full > 29'd65536)
        begin
            sz_next = 17'd65536;
        end
        else
        begin
            sz_next = sz_full[16:0];
        end

        pos_prod = 31'(lo_reg) * 31'(side);
        len_prod = 30'(sz_reg) * 30'(side);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pc_reg  <= 33'(off_c) * $signed({1'b0, center_variance});
            t_reg   <= 33'(off_s) * $signed({1'b0, size_variance});
            ac1_reg <= anchor_c;
            as1_reg <= anchor_s;
        end
        if (en[1])
        begin
            cm_reg  <= 50'(pc_reg) * $signed({34'd0, as1_reg});
            yl_reg  <= 65'(t_reg) * $signed({33'd0, LOG2E_Q30});
            ac2_reg <= ac1_reg;
            as2_reg <= as1_reg;
        end
        if (en[2])
        begin
            exp_reg <= pow2_rom[idx];
            n3_reg  <= yl_reg[64:58];
            c3_reg  <= c_next;
            as3_reg <= as2_reg;
        end
        if (en[3])
        begin
            m_reg  <= 48'(exp_reg) * 48'(as3_reg);
            n4_reg <= n3_reg;
            c4_reg <= c3_reg;
        end
        if (en[4])
        begin
            lo_reg <= lo_next;
            sz_reg <= sz_next;
        end
        if (en[5])
        begin
            pos_reg <= pos_prod[29:17];
            len_reg <= len_prod[28:16];
        end
    end

    assign pos = pos_reg;
    assign len = len_reg;

endmodule

// ===== src/anchor_box_decode_square_core.sv =====
// Top level of the anchor box decoder with square output boxes.
// An accepted input beat passes through the axis stages and the output register before its result beat.
// Throughput: one beat per cycle; each stage holds its beat only while the next is full.
// Anchors whose score is not above the threshold are dropped in the first stage.
// Reset is asynchronous and active low; it empties the pipeline and restores the registers.
module anchor_box_decode_square_core #(
    parameter int unsigned EXP_TABLE_DEPTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  abds_pkg::abds_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output abds_pkg::abds_out_t out_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_wdata
);
    import abds_pkg::*;

    localparam int unsigned NS = AXIS_STAGES + 1;

    logic [15:0] thr_reg;
    logic [15:0] cv_reg;
    logic [15:0] sv_reg;
    logic [12:0] w_reg;
    logic [12:0] h_reg;

    logic [NS:1]  valid_reg;
    logic [NS+1:1] rdy;
    logic [15:0]  score_reg [AXIS_STAGES];
    abds_out_t    out_reg;

    logic [12:0] side_in;
    logic [12:0] side_clamped;
    logic [12:0] px;
    logic [12:0] py;
    logic [12:0] pw;
    logic [12:0] ph;

    logic [12:0]        side;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
    logic signed [15:0] bw;
    logic signed [15:0] bh;
    abds_out_t          out_next;

    always_comb
    begin
        side_in = cfg_wdata[12:0];
        if (32'(side_in) > MAX_IMAGE_SIDE)
        begin
            side_clamped = 13'(MAX_IMAGE_SIDE);
        end
        else
        begin
            side_clamped = side_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= RST_SCORE_THRESHOLD;
            cv_reg  <= RST_CENTER_VARIANCE;
            sv_reg  <= RST_SIZE_VARIANCE;
            w_reg   <= RST_IMAGE_WIDTH;
            h_reg   <= RST_IMAGE_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCORE_THRESHOLD: thr_reg <= cfg_wdata;
                REG_CENTER_VARIANCE: cv_reg  <= cfg_wdata;
                REG_SIZE_VARIANCE:   sv_reg  <= cfg_wdata;
                REG_IMAGE_WIDTH:     w_reg   <= side_clamped;
                REG_IMAGE_HEIGHT:    h_reg   <= side_clamped;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        rdy[NS+1] = out_ready;
        for (int k = NS; k >= 1; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                valid_reg[1] <= in_valid && (in_data.face_score > thr_reg);
            end
            for (int k = 2; k <= NS; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            score_reg[0] <= in_data.face_score;
        end
        for (int k = 1; k < AXIS_STAGES; k++)
        begin
            if (rdy[k+1])
            begin
                score_reg[k] <= score_reg[k-1];
            end
        end
    end

    abds_axis #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_axis_x (
        .clk             (clk),
        .en              (rdy[AXIS_STAGES:1]),
        .off_c           (in_data.offset_cx),
        .off_s           (in_data.offset_w),
        .anchor_c        (in_data.anchor_cx),
        .anchor_s        (in_data.anchor_w),
        .center_variance (cv_reg),
        .size_variance   (sv_reg),
        .side            (w_reg),
        .pos             (px),
        .len             (pw)
    );

    abds_axis #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_axis_y (
        .clk             (clk),
        .en              (rdy[AXIS_STAGES:1]),
        .off_c           (in_data.offset_cy),
        .off_s           (in_data.offset_h),
        .anchor_c        (in_data.anchor_cy),
        .anchor_s        (in_data.anchor_h),
        .center_variance (cv_reg),
        .size_variance   (sv_reg),
        .side            (h_reg),
        .pos             (py),
        .len             (ph)
    );

    // The square keeps its centre; the halving truncates toward zero.
    always_comb
    begin
        side = (pw > ph) ? pw : ph;
        dx = $signed({2'b00, px, 1'b0}) + $signed({3'b000, pw}) - $signed({3'b000, side});
        dy = $signed({2'b00, py, 1'b0}) + $signed({3'b000, ph}) - $signed({3'b000, side});
        sx = (dx + $signed({15'd0, dx[15]})) >>> 1;
        sy = (dy + $signed({15'd0, dy[15]})) >>> 1;
        x1 = (sx > 0) ? sx : 16'sd0;
        y1 = (sy > 0) ? sy : 16'sd0;
        x2 = (sx + $signed({3'b000, side}) < $signed({3'b000, w_reg}))
             ? sx + $signed({3'b000, side}) : $signed({3'b000, w_reg});
        y2 = (sy + $signed({3'b000, side}) < $signed({3'b000, h_reg}))
             ? sy + $signed({3'b000, side}) : $signed({3'b000, h_reg});
        bw = x2 - x1;
        bh = y2 - y1;
        out_next.kept_score = score_reg[AXIS_STAGES-1];
        if (bw <= 0 || bh <= 0)
        begin
            out_next.box_x      = 13'd0;
            out_next.box_y      = 13'd0;
            out_next.box_width  = 13'd0;
            out_next.box_height = 13'd0;
        end
        else
        begin
            out_next.box_x      = x1[12:0];
            out_next.box_y      = y1[12:0];
            out_next.box_width  = bw[12:0];
            out_next.box_height = bh[12:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NS])
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = valid_reg[NS];
    assign out_data  = out_reg;

endmodule

// ===== src/abds_checker.sv =====
// Port checker for the anchor decoder, bound to the top level.
module abds_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input abds_pkg::abds_out_t out_data,
    input logic                out_valid,
    input logic                out_ready
);
    import abds_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Result beat changed while stalled.");

    a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.box_width == 13'd0 || out_data.box_height == 13'd0)
        |-> out_data.box_x == 13'd0 && out_data.box_y == 13'd0
            && out_data.box_width == 13'd0 && out_data.box_height == 13'd0)
        else $error("An empty box has non-zero fields.");

    a_score_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.kept_score != 16'd0)
        else $error("A zero score can never exceed the threshold.");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("Input stalled with the output stage empty.");

endmodule

bind anchor_box_decode_square_core abds_checker u_abds_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
);
